// ===== rtl/stereo_sine_drive_saturator_macros.svh =====
// -----------------------------------------------------------------------------
// Stereo sine drive saturator assertion macros
// Shorthand for clocked implication checks on i_clk, disabled while in reset.
// -----------------------------------------------------------------------------
`ifndef STEREO_SINE_DRIVE_SATURATOR_MACROS_SVH
`define STEREO_SINE_DRIVE_SATURATOR_MACROS_SVH

// Same-cycle implication.
`define SSDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssds_pkg.sv =====
// -----------------------------------------------------------------------------
// Stereo sine drive saturator package
// Shared constants and the sequencer state type.
// -----------------------------------------------------------------------------
package ssds_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int SINE_SEGMENTS_DEF = 256;

    // Drive amount register, unsigned Q1.16.
    localparam int INTENSITY_BITS = 17;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_IDX,
        ST_LO,
        ST_HI,
        ST_INTERP,
        ST_SUM,
        ST_APPLY,
        ST_ROUND,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/ssds_mul.sv =====
// -----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiply with a registered product, one result per cycle.
// -----------------------------------------------------------------------------
module ssds_mul
    import ssds_pkg::*;
#(
    parameter int OP_BITS = SAMPLE_BITS_DEF + 1
) (
    input  logic                   i_clk,
    input  logic [OP_BITS-1:0]     i_op_a,
    input  logic [OP_BITS-1:0]     i_op_b,
    output logic [2*OP_BITS-1:0]   o_prod
);

    logic [2*OP_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (2*OP_BITS)'(i_op_a) * (2*OP_BITS)'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/ssds_rom.sv =====
// -----------------------------------------------------------------------------
// Sine table
// Entries sin(k / SINE_SEGMENTS) for k = 0 .. SINE_SEGMENTS in unsigned Q(F),
// built at elaboration from a Horner series, read with a registered port.
// -----------------------------------------------------------------------------
module ssds_rom
    import ssds_pkg::*;
#(
    parameter int DATA_BITS     = SAMPLE_BITS_DEF,
    parameter int SINE_SEGMENTS = SINE_SEGMENTS_DEF,
    parameter int ADDR_BITS     = $clog2(SINE_SEGMENTS + 1)
) (
    input  logic                  i_clk,
    input  logic [ADDR_BITS-1:0]  i_addr,
    output logic [DATA_BITS-1:0]  o_data
);

    localparam int ROM_BITS = (SINE_SEGMENTS + 1) * DATA_BITS;
    localparam logic [63:0] Q31_ONE = 64'd1 << 31;

    function automatic logic [ROM_BITS-1:0] f_build();
        logic [ROM_BITS-1:0] v;
        logic [63:0]         t;
        logic [63:0]         t2;
        logic [63:0]         p;
        logic [63:0]         s;
        int                  shift;
        v     = '0;
        shift = 31 - (DATA_BITS - 1);
        for (int k = 0; k <= SINE_SEGMENTS; k++) begin
            t  = (64'(k) << 31) / SINE_SEGMENTS;
            t2 = (t * t) >> 31;
            p  = Q31_ONE - t2 / 72;
            p  = Q31_ONE - ((t2 * p) >> 31) / 42;
            p  = Q31_ONE - ((t2 * p) >> 31) / 20;
            p  = Q31_ONE - ((t2 * p) >> 31) / 6;
            s  = (t * p) >> 31;
            if (shift != 0) begin
                s = (s + (64'd1 << (shift - 1))) >> shift;
            end
            v[k*DATA_BITS +: DATA_BITS] = s[DATA_BITS-1:0];
        end
        return v;
    endfunction

    localparam logic [ROM_BITS-1:0] ROM = f_build();

    logic [DATA_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_addr <= ADDR_BITS'(SINE_SEGMENTS)) begin
            r_data <= ROM[i_addr*DATA_BITS +: DATA_BITS];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/stereo_sine_drive_saturator.sv =====
// -----------------------------------------------------------------------------
// Stereo sine drive saturator
// Each channel takes eight sequencer steps, paced by the single shared multiplier
// that forms four products per channel. A new frame is taken only once the
// previous one has moved into the output register.
// Reset (synchronous, active low) clears intensity, both previous sines and the
// output valid flag; the sine table is a constant, so no clearing pass is needed.
// -----------------------------------------------------------------------------
`include "stereo_sine_drive_saturator_macros.svh"

module stereo_sine_drive_saturator
    import ssds_pkg::*;
#(
    parameter int  SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int  SINE_SEGMENTS = SINE_SEGMENTS_DEF,
    localparam int TDATA_BITS    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: intensity, unsigned Q1.16.
    input  logic                       i_cfg_we,
    input  logic [INTENSITY_BITS-1:0]  i_cfg_wdata,
    // Input beat. tdata, from bit 0 up: left_sample, right_sample, zero padding.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [TDATA_BITS-1:0]      s_axis_tdata,
    // Output beat. tdata, from bit 0 up: left_out, right_out, zero padding.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [TDATA_BITS-1:0]      m_axis_tdata
);

    // Samples and sines are Q1.F. The multiplier takes one extra bit on each
    // operand so that |prev + sine| and the blend factor fit without loss.
    localparam int FRAC     = SAMPLE_BITS - 1;
    localparam int MUL_W    = SAMPLE_BITS + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int IDX_W    = $clog2(SINE_SEGMENTS + 1);
    localparam int OUT_W    = SAMPLE_BITS + 3;

    t_state r_state;
    t_state n_state;

    // Control state.
    logic                              r_ch;
    logic                              r_out_valid;
    logic [INTENSITY_BITS-1:0]         r_intensity;
    logic signed [SAMPLE_BITS-1:0]     r_prev_l;
    logic signed [SAMPLE_BITS-1:0]     r_prev_r;

    // Working payload.
    logic signed [SAMPLE_BITS-1:0]     r_x_l;
    logic signed [SAMPLE_BITS-1:0]     r_x_r;
    logic [IDX_W-1:0]                  r_idx;
    logic                              r_last;
    logic [FRAC-1:0]                   r_f;
    logic [SAMPLE_BITS-1:0]            r_lo;
    logic signed [SAMPLE_BITS-1:0]     r_s;
    logic [MUL_W-1:0]                  r_dmag;
    logic                              r_dneg;
    logic [SAMPLE_BITS-1:0]            r_res_l;
    logic [SAMPLE_BITS-1:0]            r_res_r;
    logic [SAMPLE_BITS-1:0]            r_out_l;
    logic [SAMPLE_BITS-1:0]            r_out_r;

    // Shared units.
    logic [MUL_W-1:0]                  w_mul_a;
    logic [MUL_W-1:0]                  w_mul_b;
    logic [PROD_W-1:0]                 w_prod;
    logic [IDX_W-1:0]                  w_rom_addr;
    logic [SAMPLE_BITS-1:0]            w_rom_data;

    // Datapath terms.
    logic                              w_in_acc;
    logic                              w_out_free;
    logic signed [SAMPLE_BITS-1:0]     w_x;
    logic signed [MUL_W-1:0]           w_x_ext;
    logic [MUL_W-1:0]                  w_abs_x;
    logic [IDX_W-1:0]                  w_idx;
    logic [SAMPLE_BITS-1:0]            w_rom_step;
    logic [SAMPLE_BITS-1:0]            w_interp;
    logic [SAMPLE_BITS-1:0]            w_mag;
    logic signed [SAMPLE_BITS-1:0]     w_sine;
    logic signed [SAMPLE_BITS-1:0]     w_prev;
    logic signed [MUL_W-1:0]           w_sum;
    logic [MUL_W-1:0]                  w_h;
    logic signed [MUL_W-1:0]           w_diff;
    logic [MUL_W-1:0]                  w_dmag;
    logic [MUL_W-1:0]                  w_apply;
    logic [PROD_W-1:0]                 w_round;
    logic [SAMPLE_BITS+1:0]            w_m;
    logic signed [OUT_W-1:0]           w_out_x;
    logic signed [OUT_W-1:0]           w_out_m;
    logic signed [OUT_W-1:0]           w_out;
    logic                              w_fits;
    logic [SAMPLE_BITS-1:0]            w_res;

    ssds_mul #(
        .OP_BITS (MUL_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_mul_a),
        .i_op_b (w_mul_b),
        .o_prod (w_prod)
    );

    ssds_rom #(
        .DATA_BITS     (SAMPLE_BITS),
        .SINE_SEGMENTS (SINE_SEGMENTS),
        .ADDR_BITS     (IDX_W)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // Handshakes. A new frame is taken only when the sequencer is idle; the
    // output register holds the finished frame so the sequencer can run ahead.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_BITS'({r_out_r, r_out_l});

    // Channel operands. The sample is widened by one bit so that its magnitude
    // at the most negative code is still representable.
    assign w_x     = r_ch ? r_x_r : r_x_l;
    assign w_prev  = r_ch ? r_prev_r : r_prev_l;
    assign w_x_ext = MUL_W'(w_x);
    assign w_abs_x = w_x[SAMPLE_BITS-1] ? $unsigned(-w_x_ext) : $unsigned(w_x_ext);

    // Table position: integer part indexes the table, fraction interpolates.
    assign w_idx = w_prod[FRAC +: IDX_W];

    // The table rises monotonically, so the step between neighbors is positive.
    assign w_rom_step = w_rom_data - r_lo;
    assign w_interp   = w_prod[FRAC +: SAMPLE_BITS];
    assign w_mag      = r_last ? r_lo : (r_lo + w_interp);
    assign w_sine     = w_x[SAMPLE_BITS-1] ? -$signed(w_mag) : $signed(w_mag);

    // Blend factor source and the distance from dry to shaped sample.
    assign w_sum  = MUL_W'(w_prev) + MUL_W'(r_s);
    assign w_h    = w_sum[MUL_W-1] ? $unsigned(-w_sum) : $unsigned(w_sum);
    assign w_diff = MUL_W'(r_s) - w_x_ext;
    assign w_dmag = w_diff[MUL_W-1] ? $unsigned(-w_diff) : $unsigned(w_diff);

    // intensity is Q1.16 with one spare bit, so the product drops 17 bits.
    assign w_apply = w_prod[INTENSITY_BITS +: MUL_W];

    // Rounding of the magnitude gives ties away from zero once the sign is
    // applied. The wide sum then saturates to the sample range.
    assign w_round = w_prod + (PROD_W'(1) << (FRAC - 1));
    assign w_m     = w_round[FRAC +: SAMPLE_BITS + 2];
    assign w_out_x = OUT_W'(w_x);
    assign w_out_m = $signed(OUT_W'(w_m));
    assign w_out   = r_dneg ? (w_out_x - w_out_m) : (w_out_x + w_out_m);
    assign w_fits  = (w_out[OUT_W-1:FRAC] == '0) || (w_out[OUT_W-1:FRAC] == '1);
    assign w_res   = w_fits ? w_out[SAMPLE_BITS-1:0]
                            : {w_out[OUT_W-1], {FRAC{~w_out[OUT_W-1]}}};

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and shared unit operands. Each channel walks the same eight
    // steps: position, index, low entry, high entry, interpolation, blend
    // source, blend factor, rounding.
    always_comb begin
        n_state    = r_state;
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_rom_addr = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_POS;
                end
            end
            ST_POS: begin
                w_mul_a = w_abs_x;
                w_mul_b = MUL_W'(SINE_SEGMENTS);
                n_state = ST_IDX;
            end
            ST_IDX: begin
                w_rom_addr = w_idx;
                n_state    = ST_LO;
            end
            ST_LO: begin
                // At full scale there is no upper neighbor; reread the last entry.
                w_rom_addr = r_last ? r_idx : (r_idx + IDX_W'(1));
                n_state    = ST_HI;
            end
            ST_HI: begin
                w_mul_a = MUL_W'(w_rom_step);
                w_mul_b = MUL_W'(r_f);
                n_state = ST_INTERP;
            end
            ST_INTERP: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                w_mul_a = w_h;
                w_mul_b = MUL_W'(r_intensity);
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                w_mul_a = r_dmag;
                w_mul_b = w_apply;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_state = r_ch ? ST_DONE : ST_POS;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers: channel select, output valid, intensity and the
    // sines kept from the previous frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
            r_intensity <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_intensity <= i_cfg_wdata;
            end
            if (w_in_acc) begin
                r_ch <= 1'b0;
            end else if ((r_state == ST_ROUND) && !r_ch) begin
                r_ch <= 1'b1;
            end
            // The present sine becomes the previous one once the blend source
            // has been formed from the old value.
            if (r_state == ST_SUM) begin
                if (r_ch) begin
                    r_prev_r <= r_s;
                end else begin
                    r_prev_l <= r_s;
                end
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x_l <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_x_r <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        case (r_state)
            ST_IDX: begin
                r_idx  <= w_idx;
                r_last <= (w_idx >= IDX_W'(SINE_SEGMENTS));
                r_f    <= w_prod[FRAC-1:0];
            end
            ST_LO: begin
                r_lo <= w_rom_data;
            end
            ST_INTERP: begin
                r_s <= w_sine;
            end
            ST_SUM: begin
                r_dmag <= w_dmag;
                r_dneg <= w_diff[MUL_W-1];
            end
            ST_ROUND: begin
                if (r_ch) begin
                    r_res_r <= w_res;
                end else begin
                    r_res_l <= w_res;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_l <= r_res_l;
                    r_out_r <= r_res_r;
                end
            end
            default: begin
            end
        endcase
    end

    // An accepted frame always starts on the left channel.
    `SSDS_ASSERT_NXT(a_accept_starts_left, w_in_acc, (r_state == ST_POS) && !r_ch, "frame did not start on left channel")
    // The scaled magnitude never points past the last table entry.
    `SSDS_ASSERT_IMP(a_index_in_table, r_state == ST_IDX, w_idx <= IDX_W'(SINE_SEGMENTS), "table index out of range")
    // A finished frame moves into a free output register and the block idles.
    `SSDS_ASSERT_NXT(a_done_loads_output, (r_state == ST_DONE) && w_out_free, m_axis_tvalid && (r_state == ST_IDLE), "finished frame not presented")

endmodule

// ===== tb/stereo_sine_drive_saturator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stereo sine drive saturator testbench
// Sends stereo Q1.23 frames into the stream input and checks every output beat
// against a local bit-accurate predictor of the sine table, the blend factor
// and the saturation. Covers directed extremes, several drive settings and a
// long randomized run. Both stream sides insert random idle gaps.
// ----------------------------------------------------------------------------
module stereo_sine_drive_saturator_test;
    import ssds_pkg::*;

    localparam int     SAMPLE_W   = SAMPLE_BITS_DEF;
    localparam int     SEGMENTS   = SINE_SEGMENTS_DEF;
    localparam int     FRAC_BITS  = SAMPLE_W - 1;
    localparam int     TDATA_W    = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam longint SAMPLE_MAX = (longint'(1) << FRAC_BITS) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) << FRAC_BITS);
    localparam logic [INTENSITY_BITS-1:0] DRIVE_OFF  = '0;
    localparam logic [INTENSITY_BITS-1:0] DRIVE_FULL = 17'd65536;
    localparam logic [INTENSITY_BITS-1:0] DRIVE_TOP  = '1;
    // Extra idle time after the last predicted frame has left the block.
    localparam int     SETTLE_CYCLES = 24;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct {
        sample_t left;
        sample_t right;
    } driven_frame_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [INTENSITY_BITS-1:0] i_cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // tdata, from bit 0 up: left_sample, right_sample.
    logic [TDATA_W-1:0]        s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // tdata, from bit 0 up: left_out, right_out.
    logic [TDATA_W-1:0]        m_axis_tdata;

    stereo_sine_drive_saturator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: its own sine knots, the drive setting as last written
    // and the sine of the previous frame on each channel.
    // ------------------------------------------------------------------------
    bit [63:0]                 sine_knots [0:SEGMENTS];
    logic [INTENSITY_BITS-1:0] drive_level = '0;
    longint                    last_sine_left = 0;
    longint                    last_sine_right = 0;

    driven_frame_t             pending_frames [$];
    int                        mismatch_count = 0;
    bit                        gaps_enabled = 1'b1;
    int                        ready_hold = 0;

    // Q31 sine by a five-term Horner series, every product floored to Q31.
    function automatic bit [63:0] q31_series_sine(input bit [63:0] t);
        bit [63:0] t2;
        bit [63:0] p;
        t2 = (t * t) >> 31;
        p  = 64'h8000_0000 - t2 / 72;
        p  = 64'h8000_0000 - ((t2 * p) >> 31) / 42;
        p  = 64'h8000_0000 - ((t2 * p) >> 31) / 20;
        p  = 64'h8000_0000 - ((t2 * p) >> 31) / 6;
        return (t * p) >> 31;
    endfunction

    // Knot k holds sin(k / SEGMENTS), rounded half up from Q31 to the sample format.
    function automatic void build_sine_knots();
        bit [63:0] k;
        bit [63:0] s;
        for (k = 0; k <= SEGMENTS; k++) begin
            s = q31_series_sine((k << 31) / SEGMENTS);
            sine_knots[k] = (s + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
        end
    endfunction

    // Odd-symmetric table sine with linear interpolation between knots.
    // A full-scale negative input lands exactly on the last knot.
    function automatic longint interp_sine(input longint x);
        bit [63:0] mag;
        bit [63:0] pos;
        bit [63:0] seg;
        bit [63:0] frac;
        bit [63:0] s;
        mag  = (x < 0) ? -x : x;
        pos  = mag * SEGMENTS;
        seg  = pos >> FRAC_BITS;
        frac = pos & ((64'd1 << FRAC_BITS) - 1);
        if (seg >= SEGMENTS) begin
            s = sine_knots[SEGMENTS];
        end else begin
            s = sine_knots[seg]
                + (((sine_knots[seg + 1] - sine_knots[seg]) * frac) >> FRAC_BITS);
        end
        return (x < 0) ? -longint'(s) : longint'(s);
    endfunction

    // Blend dry and sine by |prev + sine| / 2 * drive, rounded away from zero,
    // then clamped to the sample range.
    function automatic longint blend_drive(input longint x, input longint s,
                                           input longint prev);
        longint    sum;
        longint    diff;
        longint    res;
        bit [63:0] half_mag;
        bit [63:0] amount;
        bit [63:0] diff_mag;
        bit [63:0] step;
        sum      = prev + s;
        half_mag = (sum < 0) ? -sum : sum;
        amount   = (half_mag * 64'(drive_level)) >> 17;
        diff     = s - x;
        diff_mag = (diff < 0) ? -diff : diff;
        step     = (diff_mag * amount + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        res      = (diff < 0) ? x - longint'(step) : x + longint'(step);
        if (res > SAMPLE_MAX) res = SAMPLE_MAX;
        if (res < SAMPLE_MIN) res = SAMPLE_MIN;
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (!gaps_enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR %0t ns: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Output side. Each beat accepted at an edge is compared against the
    // oldest predicted frame; the ready line is then re-randomized for the
    // next edge. Values read here are the ones present before the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        driven_frame_t want;
        sample_t       got_left;
        sample_t       got_right;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_left  = m_axis_tdata[SAMPLE_W-1:0];
            got_right = m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("output beat %h with no frame pending",
                                          m_axis_tdata));
            end else begin
                want = pending_frames.pop_front();
                if (got_left !== want.left)
                    report_mismatch($sformatf("left_out got %h, expected %h",
                                              got_left, want.left));
                if (got_right !== want.right)
                    report_mismatch($sformatf("right_out got %h, expected %h",
                                              got_right, want.right));
            end
        end
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Input side. One frame per call: an optional idle gap, then the beat is
    // held until the block takes it, and only then is it predicted, so the
    // predictor follows the exact order of accepted frames.
    // ------------------------------------------------------------------------
    task automatic send_frame(input sample_t left, input sample_t right);
        int            gap;
        longint        sine_l;
        longint        sine_r;
        driven_frame_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sine_l          = interp_sine(left);
        sine_r          = interp_sine(right);
        want.left       = sample_t'(blend_drive(left, sine_l, last_sine_left));
        want.right      = sample_t'(blend_drive(right, sine_r, last_sine_right));
        last_sine_left  = sine_l;
        last_sine_right = sine_r;
        pending_frames.push_back(want);
    endtask

    // Let every predicted frame come out, plus the pipeline depth, so the
    // block is idle before the drive setting is touched.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_drive(input logic [INTENSITY_BITS-1:0] level);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= level;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        drive_level = level;
    endtask

    // Random samples: mostly full range, with extra weight on the rails, on
    // tiny values and on exact segment boundaries of the sine table.
    function automatic sample_t random_sample();
        sample_t v;
        case ($urandom_range(0, 9))
            5: begin
                case ($urandom_range(0, 4))
                    0: v = sample_t'(SAMPLE_MIN);
                    1: v = sample_t'(SAMPLE_MAX);
                    2: v = '0;
                    3: v = sample_t'(-1);
                    default: v = sample_t'(1);
                endcase
            end
            6, 7: v = sample_t'(int'($urandom_range(0, 4095)) - 2048);
            8: begin
                if ($urandom_range(0, 1)) v = sample_t'(SAMPLE_MAX - $urandom_range(0, 4095));
                else v = sample_t'(SAMPLE_MIN + $urandom_range(0, 4095));
            end
            9: begin
                v = sample_t'($urandom_range(0, SEGMENTS - 1)) << (FRAC_BITS - 8);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = sample_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_random_phase(input logic [INTENSITY_BITS-1:0] level,
                                    input int count);
        write_drive(level);
        repeat (count) send_frame(random_sample(), random_sample());
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Straight out of reset the drive is zero, so every sample passes unchanged.
    task automatic test_passthrough_after_reset();
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
        send_frame('0, '0);
        send_frame(sample_t'(-1), sample_t'(1));
    endtask

    // Full drive on the rails; repeating a rail lets the previous sine add up,
    // and a full-scale negative sample hits the last table knot exactly.
    task automatic test_full_drive_rails();
        write_drive(DRIVE_FULL);
        send_frame('0, '0);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
        send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN));
        send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN));
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(sample_t'(1), sample_t'(-1));
        send_frame(24'sd4194304, -24'sd4194304);
        send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    endtask

    // Drive above unity overshoots the sine; the output clamps where needed.
    task automatic test_overdrive();
        write_drive(DRIVE_TOP);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(24'sd6291456, -24'sd6291456);
        send_frame(24'sd6291456, -24'sd6291456);
        send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
        send_frame(24'sd32768, -24'sd32768);
    endtask

    // The smallest nonzero drive only nudges the samples by rounding.
    task automatic test_lightest_drive();
        write_drive(17'd1);
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
        send_frame(24'sd7340032, -24'sd7340032);
    endtask

    // A stretch with both sides always ready, to run the block at full rate.
    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        run_random_phase(INTENSITY_BITS'($urandom), 100);
        wait_idle();
        gaps_enabled = 1'b1;
    endtask

    // Long random run across several drive settings, the extremes included.
    task automatic test_random_drive();
        run_random_phase(DRIVE_FULL, 220);
        run_random_phase(INTENSITY_BITS'($urandom), 200);
        run_random_phase(DRIVE_OFF, 140);
        run_random_phase(DRIVE_TOP, 220);
        run_random_phase(INTENSITY_BITS'($urandom_range(0, 65536)), 200);
        run_random_phase(INTENSITY_BITS'($urandom), 220);
    endtask

    initial begin
        build_sine_knots();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough_after_reset();
        test_full_drive_rails();
        test_overdrive();
        test_lightest_drive();
        test_back_to_back();
        test_random_drive();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("stereo_sine_drive_saturator: match");
        end else begin
            $display("stereo_sine_drive_saturator: mismatch");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, long gaps everywhere.
    initial begin
        #6_400_000;
        $display("stereo_sine_drive_saturator: mismatch");
        $finish;
    end

endmodule
